// ===== hdl/particle_table_integrator_macros.svh =====
// Assertion macros shared by the particle table integrator.
`ifndef PARTICLE_TABLE_INTEGRATOR_MACROS_SVH
`define PARTICLE_TABLE_INTEGRATOR_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define PTI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define PTI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ptc_pkg.sv =====
// Package with types, codes and saturating arithmetic for the particle table.
package ptc_pkg;

  localparam int PTC_NUM_SLOTS = 64;

  typedef enum logic [1:0] {
    CMD_SPAWN  = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_VIEW   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_SPAWNED   = 3'd0,
    ST_FULL      = 3'd1,
    ST_UPDATED   = 3'd2,
    ST_RECORD    = 3'd3,
    ST_VIEW_NONE = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRE,
    S_SCAN,
    S_MUL,
    S_WB,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    REG_GRAVITY_X = 3'd0,
    REG_GRAVITY_Y = 3'd1,
    REG_WIND_X    = 3'd2,
    REG_WIND_Y    = 3'd3,
    REG_FLOOR_Y   = 3'd4
  } reg_e;

  // One particle as held in a cell of the ring.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] life;
    logic signed [31:0] full;
    logic [7:0]         kind;
    logic               alive;
  } particle_t;

  // Accelerations and floor from the configuration registers.
  typedef struct packed {
    logic signed [31:0] grav_x;
    logic signed [31:0] grav_y;
    logic signed [31:0] wind_x;
    logic signed [31:0] wind_y;
    logic signed [31:0] floor_y;
  } cfg_t;

  // Clamp a 33-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    return sat33(s);
  endfunction

  // Full product of a value and dt; the drop of 16 bits rounds toward minus infinity.
  function automatic logic signed [49:0] mul_dt(input logic signed [31:0] a,
                                                input logic [16:0] dt);
    logic signed [17:0] d;
    logic signed [49:0] p;
    d = $signed({1'b0, dt});
    p = a * d;
    return p;
  endfunction

  // Shift a product down by 16 and clamp it to 32 bits.
  function automatic logic signed [31:0] prod_sat(input logic signed [49:0] p);
    logic signed [33:0] q;
    logic signed [31:0] r;
    q = p[49:16];
    if ((q[33] == q[32]) && (q[32] == q[31])) begin
      r = q[31:0];
    end else begin
      r = q[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

// ===== hdl/ptc_cell.sv =====
// One cell of the particle ring: holds a particle and passes it on when the ring shifts.
module ptc_cell import ptc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      shift_i,
  input  particle_t d_i,
  output particle_t q_o
);

  logic      alive_q;
  particle_t rec_q;

  // The alive mark is control state and clears at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q <= 1'b0;
    end else if (shift_i) begin
      alive_q <= d_i.alive;
    end
  end

  // Particle payload has no reset.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      rec_q <= d_i;
    end
  end

  always_comb begin
    q_o       = rec_q;
    q_o.alive = alive_q;
  end

endmodule

// ===== hdl/ptc_euler.sv =====
// Euler step unit working on the particle at the head of the ring.
module ptc_euler import ptc_pkg::*; (
  input  logic        clk_i,
  input  logic        pre_en_i,
  input  logic        vel_en_i,
  input  logic        mul_en_i,
  input  logic [16:0] dt_i,
  input  cfg_t        cfg_i,
  input  particle_t   head_i,
  output particle_t   upd_o
);

  logic signed [31:0] gdx_q, gdy_q, wdx_q, wdy_q;
  logic signed [31:0] vx_q, vy_q;
  logic signed [49:0] px_q, py_q;
  logic signed [31:0] vx_d, vy_d;
  logic signed [31:0] nx, ny;
  logic signed [31:0] nlife;
  logic signed [32:0] ldiff;

  // Per-command acceleration terms, formed once before the sweep.
  always_ff @(posedge clk_i) begin
    if (pre_en_i) begin
      gdx_q <= prod_sat(mul_dt(cfg_i.grav_x, dt_i));
      gdy_q <= prod_sat(mul_dt(cfg_i.grav_y, dt_i));
      wdx_q <= prod_sat(mul_dt(cfg_i.wind_x, dt_i));
      wdy_q <= prod_sat(mul_dt(cfg_i.wind_y, dt_i));
    end
  end

  // Gravity first, then wind, each clamped.
  assign vx_d = sat_add(sat_add(head_i.vx, gdx_q), wdx_q);
  assign vy_d = sat_add(sat_add(head_i.vy, gdy_q), wdy_q);

  always_ff @(posedge clk_i) begin
    if (vel_en_i) begin
      vx_q <= vx_d;
      vy_q <= vy_d;
    end
    if (mul_en_i) begin
      px_q <= mul_dt(vx_q, dt_i);
      py_q <= mul_dt(vy_q, dt_i);
    end
  end

  // Position and life update, then the death test.
  assign nx    = sat_add(head_i.x, prod_sat(px_q));
  assign ny    = sat_add(head_i.y, prod_sat(py_q));
  assign ldiff = {head_i.life[31], head_i.life} - {16'b0, dt_i};
  assign nlife = sat33(ldiff);

  always_comb begin
    upd_o       = head_i;
    upd_o.x     = nx;
    upd_o.y     = ny;
    upd_o.vx    = vx_q;
    upd_o.vy    = vy_q;
    upd_o.life  = nlife;
    upd_o.alive = !((nlife <= 32'sd0) || (ny < cfg_i.floor_y));
  end

endmodule

// ===== hdl/particle_table_integrator.sv =====
// One command at a time: spawn and view sweep the whole ring once, view also waiting
// on output stalls; update scales the accelerations by dt, then sweeps with velocity,
// multiply and write-back steps at the head per alive particle. Input waits while
// busy. One result per cycle leaves through the output register unless stalled.
// Reset clears all alive marks, the alive count and the registers to their defaults.
// The particle fields themselves are not reset.
module particle_table_integrator import ptc_pkg::*; #(
  parameter int NUM_SLOTS = PTC_NUM_SLOTS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         command_i,
  input  logic [16:0]        step_time_i,
  input  logic signed [31:0] new_x_i,
  input  logic signed [31:0] new_y_i,
  input  logic signed [31:0] new_vx_i,
  input  logic signed [31:0] new_vy_i,
  input  logic signed [31:0] new_life_i,
  input  logic signed [31:0] new_full_life_i,
  input  logic [7:0]         new_kind_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_vx_o,
  output logic signed [31:0] out_vy_o,
  output logic signed [31:0] out_life_o,
  output logic signed [31:0] out_full_life_o,
  output logic [7:0]         out_kind_o,
  output logic [6:0]         alive_count_o,
  output logic               last_o
);

  `include "particle_table_integrator_macros.svh"

  localparam int SW = $clog2(NUM_SLOTS + 1);

  state_e    state_q, state_d;
  cmd_e      cmd_q;
  logic [16:0] dt_q;
  particle_t new_q;
  cfg_t      cfg_q;
  logic [SW-1:0] step_q;
  logic [6:0] cnt_q, vw_q;
  logic      placed_q;
  logic      out_valid_q;
  status_e   out_status_q;
  particle_t out_rec_q;
  logic [6:0] out_cnt_q;
  logic      out_last_q;

  particle_t cell_q [NUM_SLOTS];
  particle_t head, tail, upd;
  logic      accept, out_free, sweep_end, fin;
  logic      shift, emit, e_last, e_use_rec, cnt_inc, cnt_dec, placed_set, vw_inc;
  logic      pre_en, vel_en, mul_en;
  status_e   e_status;
  logic [6:0] e_cnt;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign head        = cell_q[0];
  assign sweep_end   = (step_q == SW'(NUM_SLOTS));
  assign fin         = (vw_q == (cnt_q - 7'd1));

  // Ring of cells; the tail takes the record that left the head.
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_ring
    if (i == NUM_SLOTS - 1) begin : g_tail
      ptc_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(shift),
        .d_i    (tail),
        .q_o    (cell_q[i])
      );
    end else begin : g_mid
      ptc_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(shift),
        .d_i    (cell_q[i+1]),
        .q_o    (cell_q[i])
      );
    end
  end

  ptc_euler u_euler (
    .clk_i   (clk_i),
    .pre_en_i(pre_en),
    .vel_en_i(vel_en),
    .mul_en_i(mul_en),
    .dt_i    (dt_q),
    .cfg_i   (cfg_q),
    .head_i  (head),
    .upd_o   (upd)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          priority case (cmd_e'(command_i))
            CMD_UPDATE: state_d = S_PRE;
            CMD_NONE:   state_d = S_IDLE;
            default:    state_d = S_SCAN;
          endcase
        end
      end
      S_PRE: state_d = S_SCAN;
      S_SCAN: begin
        if (sweep_end) begin
          state_d = S_DONE;
        end else if ((cmd_q == CMD_UPDATE) && head.alive) begin
          state_d = S_MUL;
        end
      end
      S_MUL: state_d = S_WB;
      S_WB:  state_d = S_SCAN;
      S_DONE: begin
        if (out_free || ((cmd_q == CMD_VIEW) && (cnt_q != 7'd0))) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Ring, datapath and result controls.
  always_comb begin
    shift      = 1'b0;
    tail       = head;
    emit       = 1'b0;
    e_status   = ST_UPDATED;
    e_use_rec  = 1'b0;
    e_last     = 1'b1;
    e_cnt      = cnt_q;
    cnt_inc    = 1'b0;
    cnt_dec    = 1'b0;
    placed_set = 1'b0;
    vw_inc     = 1'b0;
    pre_en     = 1'b0;
    vel_en     = 1'b0;
    mul_en     = 1'b0;
    unique case (state_q)
      S_PRE: pre_en = 1'b1;
      S_SCAN: begin
        if (!sweep_end) begin
          priority case (cmd_q)
            CMD_SPAWN: begin
              shift = 1'b1;
              if (!head.alive && !placed_q) begin
                tail       = new_q;
                placed_set = 1'b1;
                cnt_inc    = 1'b1;
              end
            end
            CMD_UPDATE: begin
              if (head.alive) begin
                vel_en = 1'b1;
              end else begin
                shift = 1'b1;
              end
            end
            default: begin
              if (!head.alive) begin
                shift = 1'b1;
              end else if (out_free) begin
                shift     = 1'b1;
                emit      = 1'b1;
                e_status  = ST_RECORD;
                e_use_rec = 1'b1;
                e_last    = fin;
                e_cnt     = fin ? cnt_q : 7'd0;
                vw_inc    = 1'b1;
              end
            end
          endcase
        end
      end
      S_MUL: mul_en = 1'b1;
      S_WB: begin
        shift   = 1'b1;
        tail    = upd;
        cnt_dec = !upd.alive;
      end
      S_DONE: begin
        priority case (cmd_q)
          CMD_SPAWN: begin
            emit     = out_free;
            e_status = placed_q ? ST_SPAWNED : ST_FULL;
          end
          CMD_UPDATE: begin
            emit     = out_free;
            e_status = ST_UPDATED;
          end
          default: begin
            emit     = out_free && (cnt_q == 7'd0);
            e_status = ST_VIEW_NONE;
          end
        endcase
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= 7'd0;
      vw_q        <= 7'd0;
      step_q      <= '0;
      placed_q    <= 1'b0;
      out_valid_q <= 1'b0;
      cmd_q       <= CMD_NONE;
      cfg_q       <= '{grav_x: 32'sd0, grav_y: 32'sd0, wind_x: 32'sd0,
                       wind_y: 32'sd0, floor_y: -32'sd3276800};
    end else begin
      state_q <= state_d;
      if (accept) begin
        cmd_q    <= cmd_e'(command_i);
        step_q   <= '0;
        vw_q     <= 7'd0;
        placed_q <= 1'b0;
      end else begin
        if (shift) step_q <= step_q + SW'(1);
        if (vw_inc) vw_q <= vw_q + 7'd1;
        if (placed_set) placed_q <= 1'b1;
      end
      if (cnt_inc) begin
        cnt_q <= cnt_q + 7'd1;
      end else if (cnt_dec) begin
        cnt_q <= cnt_q - 7'd1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        priority case (reg_e'(cfg_index_i))
          REG_GRAVITY_X: cfg_q.grav_x  <= cfg_data_i;
          REG_GRAVITY_Y: cfg_q.grav_y  <= cfg_data_i;
          REG_WIND_X:    cfg_q.wind_x  <= cfg_data_i;
          REG_WIND_Y:    cfg_q.wind_y  <= cfg_data_i;
          REG_FLOOR_Y:   cfg_q.floor_y <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Command payload and result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dt_q       <= step_time_i;
      new_q      <= '{x: new_x_i, y: new_y_i, vx: new_vx_i, vy: new_vy_i,
                      life: new_life_i, full: new_full_life_i, kind: new_kind_i,
                      alive: 1'b1};
    end
    if (emit) begin
      out_status_q <= e_status;
      out_rec_q    <= e_use_rec ? head : '0;
      out_cnt_q    <= e_cnt;
      out_last_q   <= e_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign out_x_o         = out_rec_q.x;
  assign out_y_o         = out_rec_q.y;
  assign out_vx_o        = out_rec_q.vx;
  assign out_vy_o        = out_rec_q.vy;
  assign out_life_o      = out_rec_q.life;
  assign out_full_life_o = out_rec_q.full;
  assign out_kind_o      = out_rec_q.kind;
  assign alive_count_o   = out_cnt_q;
  assign last_o          = out_last_q;

  `PTI_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= 7'(NUM_SLOTS), "alive count above table size")
  `PTI_ASSERT_NOW(a_emit_free, emit, !(out_valid_q && out_stall_i), "result overwritten")
  `PTI_ASSERT_NEXT(a_busy, accept && (command_i != CMD_NONE), state_q != S_IDLE, "command lost")

endmodule

// ===== dv/pti_checker.sv =====
// Checker for the particle table: predicts every result from the accepted items and compares.
`timescale 1ns / 1ps

module pti_checker import ptc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         command_i,
  input  logic [16:0]        step_time_i,
  input  logic signed [31:0] new_x_i,
  input  logic signed [31:0] new_y_i,
  input  logic signed [31:0] new_vx_i,
  input  logic signed [31:0] new_vy_i,
  input  logic signed [31:0] new_life_i,
  input  logic signed [31:0] new_full_life_i,
  input  logic [7:0]         new_kind_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [2:0]         status_i,
  input  logic signed [31:0] out_x_i,
  input  logic signed [31:0] out_y_i,
  input  logic signed [31:0] out_vx_i,
  input  logic signed [31:0] out_vy_i,
  input  logic signed [31:0] out_life_i,
  input  logic signed [31:0] out_full_life_i,
  input  logic [7:0]         out_kind_i,
  input  logic [6:0]         alive_count_i,
  input  logic               last_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 result_count_o,
  output int                 full_seen_o
);

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] life;
    logic signed [31:0] full;
    logic [7:0]         kind;
    logic [6:0]         count;
    logic               last;
  } result_t;

  localparam int NSLOT = PTC_NUM_SLOTS;

  // Predicted table contents and registers.
  logic signed [31:0] tab_x [NSLOT];
  logic signed [31:0] tab_y [NSLOT];
  logic signed [31:0] tab_vx [NSLOT];
  logic signed [31:0] tab_vy [NSLOT];
  logic signed [31:0] tab_life [NSLOT];
  logic signed [31:0] tab_full [NSLOT];
  logic [7:0]         tab_kind [NSLOT];
  logic               tab_alive [NSLOT];
  logic signed [31:0] grav_x, grav_y, wind_x, wind_y, floor_lvl;

  result_t pending_results[$];
  int      fails;
  int      results_seen;
  int      full_seen;

  assign fail_count_o   = fails;
  assign pending_o      = pending_results.size();
  assign result_count_o = results_seen;
  assign full_seen_o    = full_seen;

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Scale by dt: floor of the product over 2^16, then clamp.
  function automatic logic signed [31:0] scale_dt(input logic signed [31:0] a,
                                                  input logic [16:0] dt);
    longint p;
    p = longint'(a) * longint'({47'd0, dt});
    return clamp32(p >>> 16);
  endfunction

  function automatic int alive_total();
    int n;
    n = 0;
    for (int i = 0; i < NSLOT; i++) if (tab_alive[i]) n++;
    return n;
  endfunction

  function automatic void queue_result(input status_e st, input int slot,
                                       input int cnt, input logic fin);
    result_t r;
    r = '0;
    r.status = st;
    if (slot >= 0) begin
      r.x = tab_x[slot];
      r.y = tab_y[slot];
      r.vx = tab_vx[slot];
      r.vy = tab_vy[slot];
      r.life = tab_life[slot];
      r.full = tab_full[slot];
      r.kind = tab_kind[slot];
    end
    r.count = cnt[6:0];
    r.last = fin;
    pending_results.push_back(r);
  endfunction

  // Runs one accepted command against the predicted table.
  function automatic void integrate_command();
    logic signed [31:0] vx, vy;
    int free_slot, total, k;
    case (cmd_e'(command_i))
      CMD_SPAWN: begin
        free_slot = -1;
        for (int i = NSLOT - 1; i >= 0; i--) if (!tab_alive[i]) free_slot = i;
        if (free_slot < 0) begin
          full_seen++;
          queue_result(ST_FULL, -1, alive_total(), 1'b1);
        end else begin
          tab_x[free_slot] = new_x_i;
          tab_y[free_slot] = new_y_i;
          tab_vx[free_slot] = new_vx_i;
          tab_vy[free_slot] = new_vy_i;
          tab_life[free_slot] = new_life_i;
          tab_full[free_slot] = new_full_life_i;
          tab_kind[free_slot] = new_kind_i;
          tab_alive[free_slot] = 1'b1;
          queue_result(ST_SPAWNED, -1, alive_total(), 1'b1);
        end
      end
      CMD_UPDATE: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (tab_alive[i]) begin
            vx = clamp32(longint'(tab_vx[i]) + scale_dt(grav_x, step_time_i));
            vy = clamp32(longint'(tab_vy[i]) + scale_dt(grav_y, step_time_i));
            vx = clamp32(longint'(vx) + scale_dt(wind_x, step_time_i));
            vy = clamp32(longint'(vy) + scale_dt(wind_y, step_time_i));
            tab_vx[i] = vx;
            tab_vy[i] = vy;
            tab_x[i] = clamp32(longint'(tab_x[i]) + scale_dt(vx, step_time_i));
            tab_y[i] = clamp32(longint'(tab_y[i]) + scale_dt(vy, step_time_i));
            tab_life[i] = clamp32(longint'(tab_life[i]) - longint'({47'd0, step_time_i}));
            if (tab_life[i] <= 0 || tab_y[i] < floor_lvl) tab_alive[i] = 1'b0;
          end
        end
        queue_result(ST_UPDATED, -1, alive_total(), 1'b1);
      end
      CMD_VIEW: begin
        total = alive_total();
        k = 0;
        if (total == 0) begin
          queue_result(ST_VIEW_NONE, -1, 0, 1'b1);
        end else begin
          for (int i = 0; i < NSLOT; i++) begin
            if (tab_alive[i]) begin
              queue_result(ST_RECORD, i, (k == total - 1) ? total : 0, k == total - 1);
              k++;
            end
          end
        end
      end
      default: begin
        // The unused code causes nothing.
      end
    endcase
  endfunction

  initial begin
    fails = 0;
    results_seen = 0;
    full_seen = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, want;
    if (!rst_ni) begin
      for (int i = 0; i < NSLOT; i++) tab_alive[i] = 1'b0;
      grav_x = '0;
      grav_y = '0;
      wind_x = '0;
      wind_y = '0;
      floor_lvl = -32'sd3276800;
    end else begin
      // Compare a result leaving the block with the oldest prediction.
      if (out_valid_i && !out_stall_i) begin
        results_seen++;
        got = {status_i, out_x_i, out_y_i, out_vx_i, out_vy_i, out_life_i,
               out_full_life_i, out_kind_i, alive_count_i, last_i};
        if (pending_results.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result: status %0d", status_i);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status || got.x !== want.x || got.y !== want.y ||
              got.vx !== want.vx || got.vy !== want.vy || got.life !== want.life ||
              got.full !== want.full || got.kind !== want.kind ||
              got.count !== want.count || got.last !== want.last) begin
            fails++;
            if (fails <= 10) begin
              $display("mismatch: expected st %0d x %h y %h vx %h vy %h life %h full %h",
                       want.status, want.x, want.y, want.vx, want.vy, want.life, want.full);
              $display("          kind %h cnt %0d last %0d", want.kind, want.count,
                       want.last);
              $display("  actual: st %0d x %h y %h vx %h vy %h life %h full %h",
                       got.status, got.x, got.y, got.vx, got.vy, got.life, got.full);
              $display("          kind %h cnt %0d last %0d", got.kind, got.count,
                       got.last);
            end
          end
        end
      end
      // Register writes.
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_e'(cfg_index_i))
          REG_GRAVITY_X: grav_x = cfg_data_i;
          REG_GRAVITY_Y: grav_y = cfg_data_i;
          REG_WIND_X:    wind_x = cfg_data_i;
          REG_WIND_Y:    wind_y = cfg_data_i;
          REG_FLOOR_Y:   floor_lvl = cfg_data_i;
          default: ;
        endcase
      end
      // Commands.
      if (in_valid_i && !in_stall_i) integrate_command();
    end
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the particle table testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import ptc_pkg::*;

  localparam int WATCH_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 300;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         command_i = CMD_NONE;
  logic [16:0]        step_time_i = '0;
  logic signed [31:0] new_x_i = '0;
  logic signed [31:0] new_y_i = '0;
  logic signed [31:0] new_vx_i = '0;
  logic signed [31:0] new_vy_i = '0;
  logic signed [31:0] new_life_i = '0;
  logic signed [31:0] new_full_life_i = '0;
  logic [7:0]         new_kind_i = '0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         status_o;
  logic signed [31:0] out_x_o, out_y_o, out_vx_o, out_vy_o, out_life_o, out_full_life_o;
  logic [7:0]         out_kind_o;
  logic [6:0]         alive_count_o;
  logic               last_o;

  int  fail_count, pending, result_count, full_seen;
  bit  idle_en = 1'b1;
  int  hold_requests = 0;
  int  items_sent = 0;
  int  quiet_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  particle_table_integrator u_top (.*);

  pti_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .command_i, .step_time_i,
    .new_x_i, .new_y_i, .new_vx_i, .new_vy_i, .new_life_i, .new_full_life_i,
    .new_kind_i, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .status_i(status_o), .out_x_i(out_x_o),
    .out_y_i(out_y_o), .out_vx_i(out_vx_o), .out_vy_i(out_vy_o), .out_life_i(out_life_o),
    .out_full_life_i(out_full_life_o), .out_kind_i(out_kind_o),
    .alive_count_i(alive_count_o), .last_i(last_o), .fail_count_o(fail_count),
    .pending_o(pending), .result_count_o(result_count), .full_seen_o(full_seen)
  );

  // Receiver side: random stall bursts, plus long hold-offs on request.
  initial begin
    int seen_holds;
    seen_holds = 0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != seen_holds) begin
        seen_holds = hold_requests;
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog on cycles where no channel moves anything.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCH_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one item and holds it until the block takes it.
  task automatic send_item(input cmd_e cmd, input logic [16:0] dt,
                           input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] vx, input logic [31:0] vy,
                           input logic [31:0] life, input logic [31:0] full,
                           input logic [7:0] knd);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    step_time_i <= dt;
    new_x_i <= x;
    new_y_i <= y;
    new_vx_i <= vx;
    new_vy_i <= vy;
    new_life_i <= life;
    new_full_life_i <= full;
    new_kind_i <= knd;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Spawn with plausible content most of the time, fully random otherwise.
  task automatic spawn_random();
    if ($urandom_range(0, 7) == 0) begin
      send_item(CMD_SPAWN, 17'($urandom), $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, 8'($urandom));
    end else begin
      send_item(CMD_SPAWN, 17'($urandom), $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000,
                $urandom_range(0, 32'h03E8_0000), $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
                $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
                $urandom_range(1, 32'h0020_0000), $urandom, 8'($urandom));
    end
  endtask

  function automatic logic [16:0] random_dt();
    case ($urandom_range(0, 5))
      0: return 17'($urandom_range(0, 131071));
      1: return 17'd65536;
      default: return 17'($urandom_range(0, 8192));
    endcase
  endfunction

  task automatic send_other();
    case ($urandom_range(0, 9))
      0, 1, 2: send_item(CMD_UPDATE, random_dt(), $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, 8'($urandom));
      3, 4: send_item(CMD_VIEW, 17'($urandom), $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, 8'($urandom));
      5: send_item(CMD_NONE, 17'($urandom), $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, 8'($urandom));
      default: spawn_random();
    endcase
  endtask

  // Lets the block drain before a register write.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_all(input logic [31:0] gx, input logic [31:0] gy,
                           input logic [31:0] wx, input logic [31:0] wy,
                           input logic [31:0] fl);
    write_reg(REG_GRAVITY_X, gx);
    write_reg(REG_GRAVITY_Y, gy);
    write_reg(REG_WIND_X, wx);
    write_reg(REG_WIND_Y, wy);
    write_reg(REG_FLOOR_Y, fl);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty view, ignored code, extremes of the fields and of dt.
    write_all(32'h0000_8000, 32'hFFF6_0000, 32'h0001_0000, 32'h0, 32'hFF38_0000);
    send_item(CMD_VIEW, '0, '0, '0, '0, '0, '0, '0, '0);
    send_item(CMD_NONE, '1, '1, '1, '1, '1, '1, '1, '1);
    send_item(CMD_SPAWN, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'hFF);
    send_item(CMD_SPAWN, '0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 8'h00);
    send_item(CMD_SPAWN, '0, '0, 32'h0064_0000, '0, 32'h8000_0000, 32'h0000_0001, '0, 8'h5A);
    send_item(CMD_SPAWN, '0, '0, 32'h0010_0000, '0, '0, 32'h0100_0000, 32'h0100_0000, 8'hA5);
    send_item(CMD_VIEW, '0, '0, '0, '0, '0, '0, '0, '0);
    send_item(CMD_UPDATE, 17'd0, '0, '0, '0, '0, '0, '0, '0);
    send_item(CMD_VIEW, '0, '0, '0, '0, '0, '0, '0, '0);
    send_item(CMD_UPDATE, 17'd65536, '0, '0, '0, '0, '0, '0, '0);
    send_item(CMD_UPDATE, 17'h1FFFF, '0, '0, '0, '0, '0, '0, '0);
    send_item(CMD_VIEW, '0, '0, '0, '0, '0, '0, '0, '0);

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h8000_0000);
        1: write_all('0, '0, '0, '0, 32'h8000_0000);
        2: write_all(32'h0000_1000, 32'hFFFF_0000, 32'hFFFF_F000, 32'h0000_0800,
                     32'h7FFF_FFFF);
        5: write_all('0, 32'hFFFF_C000, 32'h0000_2000, '0, 32'hFC18_0000);
        default: write_all($urandom_range(0, 32'h3FFFF) - 32'h1FFFF,
                           $urandom_range(0, 32'h3FFFF) - 32'h1FFFF, $urandom, $urandom,
                           $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000);
      endcase
      if (ph == 5) idle_en = 1'b0;
      if (ph == 1) begin
        // Fill the table under a stalled receiver, then overflow it.
        hold_requests = hold_requests + 1;
        for (int i = 0; i < 66; i++) spawn_random();
        send_item(CMD_VIEW, '0, '0, '0, '0, '0, '0, '0, '0);
        send_item(CMD_UPDATE, random_dt(), '0, '0, '0, '0, '0, '0, '0);
      end else begin
        for (int i = 0; i < 15; i++) begin
          if (i == 7) begin
            // Sender waits for every outstanding result.
            in_valid_i <= 1'b0;
            @(posedge clk_i);
            while (pending != 0) @(posedge clk_i);
          end
          send_other();
        end
        send_item(CMD_VIEW, '0, '0, '0, '0, '0, '0, '0, '0);
      end
    end

    // Wrap up once everything has come back.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Ran %0d commands with %0d results over six register settings,", items_sent,
             result_count);
    $display("including a full table (%0d rejected spawns) and long output stalls.",
             full_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ptc_pkg.sv
hdl/ptc_cell.sv
hdl/ptc_euler.sv
hdl/particle_table_integrator.sv
dv/pti_checker.sv
dv/testbench.sv
